[sv/mt64_pkg.sv]
`default_nettype none

package mt64_pkg;

    // Geometry of the state store
    localparam int STATE_DEPTH = 312;
    localparam int SHIFT_DEPTH = 156;
    localparam int IDX_W       = 9;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_DEPTH - 1);
    localparam logic [IDX_W-1:0] SHIFT_IDX = IDX_W'(SHIFT_DEPTH);

    // Seeding constants
    localparam logic [63:0] SEED_CONSTANT = 64'h0000_0A54_2B23_4C76;
    localparam logic [63:0] SEED_MULT     = 64'd6364136223846793005;

    // Twist constants
    localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;

    // Tempering masks
    localparam logic [63:0] TEMPER_MASK_A = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TEMPER_MASK_B = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TEMPER_MASK_C = 64'hFFF7_EEE0_0000_0000;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_INIT,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_FETCH,
        ST_TWIST
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic seed_init;
        logic seed_mul;
        logic seed_add;
        logic fetch;
        logic twist;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic seeded;
        logic seed_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[sv/mt64_ctrl.sv]
`default_nettype none

module mt64_ctrl
    import mt64_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  draw_valid,
    input  wire logic  draw_request,
    output logic       draw_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign draw_stall = (state_reg != ST_IDLE);
    assign accept     = draw_valid && !draw_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && draw_request)
                begin
                    state_next = stat.seeded ? ST_FETCH : ST_SEED_INIT;
                end
            end
            ST_SEED_INIT: state_next = ST_SEED_MUL;
            ST_SEED_MUL:  state_next = ST_SEED_ADD;
            ST_SEED_ADD:  state_next = stat.seed_last ? ST_FETCH : ST_SEED_MUL;
            ST_FETCH:     state_next = ST_TWIST;
            ST_TWIST:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:      cmd = '0;
            ST_SEED_INIT: cmd.seed_init = 1'b1;
            ST_SEED_MUL:  cmd.seed_mul  = 1'b1;
            ST_SEED_ADD:  cmd.seed_add  = 1'b1;
            ST_FETCH:     cmd.fetch     = 1'b1;
            ST_TWIST:     cmd.twist     = stat.out_free;
            default:      cmd = '0;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[sv/mt64_dpath.sv]
`default_nettype none

module mt64_dpath
    import mt64_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        seed_valid,
    input  wire logic        seed_ready,
    input  wire logic [63:0] seed_value,
    input  wire logic        result_stall,
    output logic             result_valid,
    output logic      [63:0] random_word,
    output logic      [52:0] unit_fraction,
    input  wire cmd_t        cmd,
    output stat_t            stat
);

    // State store
    logic [63:0] mem [STATE_DEPTH];

    logic [63:0]      seed_reg;
    logic [63:0]      seed_next;
    logic             seeded_reg;
    logic             seeded_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [IDX_W-1:0] sidx_reg;
    logic [IDX_W-1:0] sidx_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [63:0] prev_reg;
    logic [63:0] prev_next;
    logic [63:0] cur_reg;
    logic [63:0] cur_next;
    logic [63:0] p_ll_reg;
    logic [31:0] p_hl_reg;
    logic [31:0] p_lh_reg;
    logic [63:0] rd_a_reg;
    logic [63:0] rd_b_reg;
    logic [63:0] word_reg;
    logic [63:0] word_next;

    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic [63:0]      word0;
    logic [63:0]      mix;
    logic [63:0]      seed_sum;
    logic [63:0]      twist_y;
    logic [63:0]      twist_v;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0]      wr_data;

    function automatic logic [63:0] temper(input logic [63:0] x);
        logic [63:0] t;
        t = x;
        t = t ^ ((t >> 29) & TEMPER_MASK_A);
        t = t ^ ((t << 17) & TEMPER_MASK_B);
        t = t ^ ((t << 37) & TEMPER_MASK_C);
        t = t ^ (t >> 43);
        return t;
    endfunction

    // Neighbor addresses of the word being twisted
    assign addr_a = (pos_reg == LAST_IDX) ? '0 : pos_reg + IDX_W'(1);
    assign addr_b = (pos_reg < SHIFT_IDX) ? pos_reg + SHIFT_IDX : pos_reg - SHIFT_IDX;

    // Seeding recurrence
    assign word0    = seed_reg | SEED_CONSTANT;
    assign mix      = prev_reg ^ (prev_reg >> 62);
    assign seed_sum = p_ll_reg + {p_hl_reg + p_lh_reg, 32'b0} + 64'(sidx_reg);

    // Twist of one word
    assign twist_y = (cur_reg & UPPER_MASK) | (rd_a_reg & LOWER_MASK);
    assign twist_v = rd_b_reg ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 64'b0);

    // Write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = twist_v;
        priority if (cmd.seed_init)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = word0;
        end
        else if (cmd.seed_add)
        begin
            wr_en   = 1'b1;
            wr_addr = sidx_reg;
            wr_data = seed_sum;
        end
        else if (cmd.twist)
        begin
            wr_en   = 1'b1;
        end
    end

    // Control next values
    always_comb
    begin
        seed_next      = seed_reg;
        seeded_next    = seeded_reg;
        pos_next       = pos_reg;
        sidx_next      = sidx_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (seed_valid && seed_ready)
        begin
            seed_next = seed_value;
        end
        if (cmd.seed_init)
        begin
            seeded_next = 1'b1;
            pos_next    = '0;
            sidx_next   = IDX_W'(1);
        end
        if (cmd.seed_add)
        begin
            sidx_next = sidx_reg + IDX_W'(1);
        end
        if (cmd.twist)
        begin
            pos_next       = addr_a;
            out_valid_next = 1'b1;
        end
    end

    // Payload next values
    always_comb
    begin
        prev_next = prev_reg;
        cur_next  = cur_reg;
        word_next = word_reg;
        if (cmd.seed_init)
        begin
            prev_next = word0;
            cur_next  = word0;
        end
        if (cmd.seed_add)
        begin
            prev_next = seed_sum;
        end
        if (cmd.twist)
        begin
            cur_next  = rd_a_reg;
            word_next = temper(twist_v);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            seeded_reg    <= 1'b0;
            pos_reg       <= '0;
            sidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            seeded_reg    <= seeded_next;
            pos_reg       <= pos_next;
            sidx_reg      <= sidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        word_reg <= word_next;
        if (cmd.seed_mul)
        begin
            p_ll_reg <= 64'(mix[31:0]) * 64'(SEED_MULT[31:0]);
            p_hl_reg <= 32'(mix[63:32] * SEED_MULT[31:0]);
            p_lh_reg <= 32'(mix[31:0] * SEED_MULT[63:32]);
        end
    end

    // Memory write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Memory read, two ports
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    assign stat.seeded    = seeded_reg;
    assign stat.seed_last = (sidx_reg == LAST_IDX);
    assign stat.out_free  = !out_valid_reg || !result_stall;

    assign result_valid  = out_valid_reg;
    assign random_word   = word_reg;
    assign unit_fraction = word_reg[63:11];

endmodule

`default_nettype wire

[sv/mersenne_twister_64_generator_unit.sv]
// Channel   Direction  Handshake               Payload
// draw      in         draw_valid/draw_stall   draw_request
// result    out        result_valid/result_stall random_word, unit_fraction
// seed      in         seed_valid/seed_ready   seed_value
//
// A draw steps through accept, fetch of two neighbor words from the
// two-read-port state memory, and twist and temper into the output register
// once it is free. The first draw after reset first seeds the state: word 0
// from the seed, then each other word through the split seed multiplier.
// Reset clears control state; the state words are written by seeding.
// A stalled result holds; the next draw is taken while it waits.
`default_nettype none

module mersenne_twister_64_generator_unit
    import mt64_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        draw_valid,
    output logic             draw_stall,
    input  wire logic        draw_request,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic      [63:0] random_word,
    output logic      [52:0] unit_fraction,
    input  wire logic        seed_valid,
    output logic             seed_ready,
    input  wire logic [63:0] seed_value
);

    cmd_t  cmd;
    stat_t stat;

    // Seed register takes a write any cycle
    assign seed_ready = 1'b1;

    mt64_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .draw_valid   (draw_valid),
        .draw_request (draw_request),
        .draw_stall   (draw_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    mt64_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed_valid    (seed_valid),
        .seed_ready    (seed_ready),
        .seed_value    (seed_value),
        .result_stall  (result_stall),
        .result_valid  (result_valid),
        .random_word   (random_word),
        .unit_fraction (unit_fraction),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

`default_nettype wire

[sv/mt64_chk.sv]
`default_nettype none

module mt64_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        draw_valid,
    input wire logic        draw_stall,
    input wire logic        draw_request,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [63:0] random_word,
    input wire logic [52:0] unit_fraction
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(random_word))
        else $error("stalled result changed");

    // Fraction is the top of the word
    a_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (unit_fraction == random_word[63:11]))
        else $error("unit_fraction does not match random_word");

    // A real request keeps the draw side busy while it is fetched and twisted, or while seeding begins
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid && !draw_stall && draw_request |=> draw_stall ##1 draw_stall)
        else $error("draw taken too early");

    // An empty request is dropped at once
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid && !draw_stall && !draw_request |=> !draw_stall)
        else $error("empty request stalled the draw side");

endmodule

bind mersenne_twister_64_generator_unit mt64_chk u_chk (.*);

`default_nettype wire
